[rtl/core/spq_pkg.sv]
// Shared types and codes for the sorted priority queue core.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;
  localparam int POS_W  = 4;
  localparam int OCC_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd2;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] operand;
  } spq_ctrl_t;

  // What one cell shows its neighbors
  typedef struct packed {
    logic                     valid;
    logic                     gt;
    logic signed [DATA_W-1:0] value;
  } spq_link_t;

endpackage

[rtl/core/spq_cell.sv]
// One storage cell of the sorted queue: holds an entry, compares, shifts.
`timescale 1ns / 1ps
module spq_cell (
  input  logic              clk,
  input  logic              rst,
  input  spq_pkg::spq_ctrl_t ctrl,
  input  spq_pkg::spq_link_t left,
  input  spq_pkg::spq_link_t right,
  output spq_pkg::spq_link_t own,
  output logic              eq,
  output logic              bnd
);
  import spq_pkg::*;

  logic                     valid;
  logic                     valid_next;
  logic signed [DATA_W-1:0] value;
  logic signed [DATA_W-1:0] value_next;
  logic                     gt;

  // Compare the stored entry against the broadcast operand
  assign gt  = valid && (value > ctrl.operand);
  assign eq  = valid && (value == ctrl.operand);
  // First cell not greater than the operand
  assign bnd = !gt && left.gt;

  assign own.valid = valid;
  assign own.gt    = gt;
  assign own.value = value;

  // Take the new word, shift in from the left, or close the gap from the right
  always_comb begin
    value_next = value;
    valid_next = valid;
    if (ctrl.ins) begin
      if (!gt && left.gt) begin
        value_next = ctrl.operand;
        valid_next = 1'b1;
      end else if (!left.gt && left.valid) begin
        value_next = left.value;
        valid_next = 1'b1;
      end
    end else if (ctrl.rem && !gt) begin
      value_next = right.value;
      valid_next = right.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

[rtl/core/sorted_priority_queue_core.sv]
// Top level of the sorted priority queue: cell chain, controller, result register.
// The result strobe is registered and rises in the cycle after start is accepted.
// Throughput: one operation per cycle; the compare and shift are combinational in the
// cell chain, so busy stays low.
// Reset: synchronous, active high; empties the queue and drops any pending result.
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module sorted_priority_queue_core #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [spq_pkg::OP_W-1:0]          opcode,
  input  logic signed [spq_pkg::DATA_W-1:0] operand_value,
  output logic                              done,
  output logic [spq_pkg::ST_W-1:0]          status,
  output logic [spq_pkg::POS_W-1:0]         position,
  output logic [spq_pkg::OCC_W-1:0]         occupancy,
  output logic signed [spq_pkg::DATA_W-1:0] head_value,
  output logic                              is_empty
);
  import spq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  spq_ctrl_t        ctrl;
  spq_link_t        lnk      [DEPTH];
  spq_link_t        left_in  [DEPTH];
  spq_link_t        right_in [DEPTH];
  logic [DEPTH-1:0] eq_vec;
  logic [DEPTH-1:0] bnd_vec;
  logic [DEPTH-1:0] valid_vec;

  logic          accept;
  logic          found;
  logic          full;
  logic [IW-1:0] pos_idx;
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [ST_W-1:0]  status_next;
  logic [POS_W-1:0] position_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  assign found = |eq_vec;
  assign full  = (count == CW'(DEPTH));

  // Drive the broadcast controls
  assign ctrl.ins     = accept && (opcode == OP_INSERT) && !full;
  assign ctrl.rem     = accept && (opcode == OP_REMOVE) && found;
  assign ctrl.operand = operand_value;

  // Build the cell chain
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i] = '{valid: 1'b1, gt: 1'b1, value: '0};
    end else begin : g_mid
      assign left_in[i] = lnk[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_in[i] = '{valid: 1'b0, gt: 1'b0, value: '0};
    end else begin : g_inner
      assign right_in[i] = lnk[i+1];
    end
    assign valid_vec[i] = lnk[i].valid;

    spq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  (left_in[i]),
      .right (right_in[i]),
      .own   (lnk[i]),
      .eq    (eq_vec[i]),
      .bnd   (bnd_vec[i])
    );
  end

  // Encode the one-hot boundary into an index
  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (bnd_vec[i]) begin
        pos_idx = pos_idx | IW'(i);
      end
    end
  end

  // Decide status, position and the new count
  always_comb begin
    status_next   = ST_NOT_FOUND;
    position_next = '0;
    count_next    = count;
    unique case (opcode)
      OP_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next   = ST_OK;
          position_next = POS_W'(pos_idx);
          count_next    = count + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          status_next   = ST_OK;
          position_next = POS_W'(pos_idx);
          count_next    = count - CW'(1);
        end
      end
      OP_FIND: begin
        if (found) begin
          status_next   = ST_OK;
          position_next = POS_W'(pos_idx);
        end
      end
      default: begin
        status_next = ST_NOT_FOUND;
      end
    endcase
  end

  // Hold the count and the result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status   <= status_next;
      position <= position_next;
    end
  end

  // State after the operation: occupancy and empty flag from the count, head straight from the chain
  assign occupancy  = OCC_W'(count);
  assign is_empty   = (count == '0);
  assign head_value = lnk[0].valid ? lnk[0].value : '0;

  a_done_follows_accept : assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("result strobe without an accepted word");

  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("occupancy exceeds depth");

  a_valid_packed : assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + DEPTH'(1)) & valid_vec) == '0)
    else $error("valid cells not packed at the head");

  a_count_matches : assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == int'(count))
    else $error("count disagrees with valid cells");

endmodule
